// File: hdl/lse_pkg.sv
// Shared types and constants for the LIFO stack engine.
`default_nettype none

package lse_pkg;

  // Number of words the stack holds.
  localparam int DEPTH = 64;
  // Word width of a stored element.
  localparam int DATA_W = 32;
  // Element count must be able to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Index of a cell in the chain.
  localparam int IDX_W = $clog2(DEPTH);
  // Result tdata: element, empty flag, full flag, padded to whole bytes.
  localparam int OUT_BITS = DATA_W + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_DUMP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2
  } status_e;

  // What every cell of the chain does in one cycle.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // Control broadcast from the sequencer to the cell chain.
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] bot_idx;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lse_cell.sv
// One storage cell of the stack chain.
`default_nettype none

module lse_cell
  import lse_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire cell_op_e                 op_i,
  input  wire logic                     bottom_i,
  input  wire logic signed [DATA_W-1:0] prev_i,
  input  wire logic signed [DATA_W-1:0] next_i,
  input  wire logic signed [DATA_W-1:0] top_i,
  output logic signed      [DATA_W-1:0] data_o
);

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  // Push moves words away from the top, pop moves them toward it, and a
  // rotation also closes the ring by loading the old top into the bottom cell.
  always_comb begin
    case (op_i)
      OP_PUSH: data_d = prev_i;
      OP_POP:  data_d = next_i;
      OP_ROT:  data_d = bottom_i ? top_i : next_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: hdl/lse_chain.sv
// Row of storage cells that forms the stack, top word in cell zero.
`default_nettype none

module lse_chain
  import lse_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire chain_ctrl_t              ctrl_i,
  input  wire logic signed [DATA_W-1:0] push_value_i,
  output logic signed      [DATA_W-1:0] top_o
);

  logic signed [DATA_W-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = push_value_i;
    end else begin : g_inner_prev
      assign prev = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner_next
      assign next = cell_data[i+1];
    end

    lse_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (ctrl_i.op),
      .bottom_i (ctrl_i.bot_idx == IDX_W'(i)),
      .prev_i   (prev),
      .next_i   (next),
      .top_i    (cell_data[0]),
      .data_o   (cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

`default_nettype wire

// File: hdl/lifo_stack_engine.sv
// Top level of the LIFO stack engine: sequencer, cell chain and result register.
// A result is in the output register in the cycle after its item is accepted.
// Push, pop and peek are taken at one item per cycle while the output register is free.
// A dump of N stored words gives N results, one per cycle unless stalled, and holds off input.
// Rate is set by the single top cell, the only word the chain presents each cycle.
// Reset clears the count, the sequencer and the output valid; stored words are not reset.
`default_nettype none

module lifo_stack_engine
  import lse_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] push_value
  input  wire logic [1:0]             s_axis_tuser,  // [1:0] func

  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [31:0] data, [32] is_empty,
                                                     // [33] is_full, rest zero
  output logic [1:0]                  m_axis_tuser,  // [1:0] status
  output logic                        m_axis_tlast   // last result of the item
);

  // Sequencer state: idle takes items, dump walks the stack one word a cycle unless stalled.
  state_e state_q, state_d;

  // Number of stored words, and words still to be dumped.
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;

  // Output register.
  logic                     m_valid_q, m_valid_d;
  logic signed [DATA_W-1:0] m_data_q, m_data_d;
  status_e                  m_status_q, m_status_d;
  logic                     m_empty_q, m_empty_d;
  logic                     m_full_q, m_full_d;
  logic                     m_last_q, m_last_d;

  chain_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] top_word;

  logic  out_free;
  logic  in_fire;
  logic  dump_step;
  logic  is_empty;
  logic  is_full;
  func_e func;

  assign func      = func_e'(s_axis_tuser);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(DEPTH));

  // The result register frees up in the same cycle it is taken.
  assign out_free  = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign dump_step = (state_q == ST_DUMP) && out_free;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        // A dump of more than one word keeps walking after its first result.
        if (in_fire && func == FUNC_DUMP && count_q > CNT_W'(1)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_step && left_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control, count update and result formation.
  always_comb begin
    count_d      = count_q;
    left_d       = left_q;
    ctrl.op      = OP_HOLD;
    // During a rotation the bottom cell is the one at count - 1.
    ctrl.bot_idx = IDX_W'(count_q - CNT_W'(1));
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_status_d   = m_status_q;
    m_last_d     = m_last_q;

    if (in_fire) begin
      m_valid_d  = 1'b1;
      m_data_d   = '0;
      m_status_d = STAT_OK;
      m_last_d   = 1'b1;
      unique case (func)
        FUNC_PUSH: begin
          if (is_full) begin
            m_status_d = STAT_OVER;
          end else begin
            ctrl.op = OP_PUSH;
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_POP: begin
          if (is_empty) begin
            m_status_d = STAT_UNDER;
          end else begin
            m_data_d = top_word;
            ctrl.op  = OP_POP;
            count_d  = count_q - CNT_W'(1);
          end
        end
        FUNC_PEEK: begin
          if (is_empty) begin
            m_status_d = STAT_UNDER;
          end else begin
            m_data_d = top_word;
          end
        end
        FUNC_DUMP: begin
          if (is_empty) begin
            m_status_d = STAT_UNDER;
          end else begin
            // Emit the top word now and rotate it to the bottom; after
            // count rotations the stack is back in its original order.
            m_data_d = top_word;
            ctrl.op  = OP_ROT;
            m_last_d = (count_q == CNT_W'(1));
            left_d   = count_q - CNT_W'(1);
          end
        end
        default: m_status_d = STAT_UNDER;
      endcase
    end else if (dump_step) begin
      m_valid_d  = 1'b1;
      m_data_d   = top_word;
      m_status_d = STAT_OK;
      ctrl.op    = OP_ROT;
      m_last_d   = (left_q == CNT_W'(1));
      left_d     = left_q - CNT_W'(1);
    end

    // Flags report the stack as it stands after the step.
    m_empty_d = (count_d == '0);
    m_full_d  = (count_d == CNT_W'(DEPTH));
    if (!(in_fire || dump_step)) begin
      m_empty_d = m_empty_q;
      m_full_d  = m_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      left_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      left_q    <= left_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q   <= m_data_d;
    m_status_q <= m_status_d;
    m_empty_q  <= m_empty_d;
    m_full_q   <= m_full_d;
    m_last_q   <= m_last_d;
  end

  lse_chain u_chain (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .push_value_i (s_axis_tdata),
    .top_o        (top_word)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), m_full_q, m_empty_q, m_data_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// File: hdl/lse_checker.sv
// Port-level assertions for the LIFO stack engine, bound to the top level.
`default_nettype none

module lse_checker
  import lse_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]             m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Empty and full cannot both hold for a stack of two or more words.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[DATA_W] && m_axis_tdata[DATA_W+1]))
    else $error("empty and full at once");

  // Overflow only on a full stack, underflow only on an empty one, both final.
  a_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_OVER || m_axis_tuser == STAT_UNDER)
    |-> m_axis_tlast && m_axis_tdata[DATA_W-1:0] == '0
        && (m_axis_tuser == STAT_OVER ? m_axis_tdata[DATA_W+1] : m_axis_tdata[DATA_W]))
    else $error("error result inconsistent with flags");

  // While a dump is still producing words no new item is taken.
  a_dump_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("item accepted during a dump");

endmodule

bind lifo_stack_engine lse_checker u_lse_checker (.*);

`default_nettype wire

// File: tb/sv/lifo_stack_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the LIFO stack engine with its own stack predictor.
module lifo_stack_engine_tb;
  import lse_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_PCT = 26;
  localparam int MAX_SHOWN = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 120;
  localparam int BURST_ITEMS = 60;
  localparam int HOLD_ITEMS = 24;
  localparam int HOLD_CYCLES = 300;
  // Far beyond the slowest correct run: every dump at full depth with stalls on each word.
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // One result as the stack should report it.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic              empty;
    logic              full;
    logic              tlast;
  } stack_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire [1:0]              m_axis_tuser;
  wire                    m_axis_tlast;

  // Predicted stack contents and the results still owed by the block.
  logic [DATA_W-1:0] stack_words [DEPTH];
  int unsigned       stack_count = 0;
  stack_result_t     owed_results[$];

  int unsigned mismatch_count = 0;
  bit          idle_en = 1'b1;
  int unsigned sink_hold_req = 0;

  lifo_stack_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Flags are taken from the predicted count after the operation has been applied.
  function automatic stack_result_t make_result(logic [DATA_W-1:0] word, status_e st,
                                                logic is_last);
    stack_result_t r;
    r.data   = word;
    r.status = st;
    r.empty  = (stack_count == 0);
    r.full   = (stack_count == DEPTH);
    r.tlast  = is_last;
    return r;
  endfunction

  function automatic void predict_stack_op(func_e op, logic [DATA_W-1:0] value);
    case (op)
      FUNC_PUSH: begin
        if (stack_count == DEPTH) begin
          owed_results.push_back(make_result('0, STAT_OVER, 1'b1));
        end else begin
          stack_words[stack_count] = value;
          stack_count++;
          owed_results.push_back(make_result('0, STAT_OK, 1'b1));
        end
      end
      FUNC_POP: begin
        if (stack_count == 0) begin
          owed_results.push_back(make_result('0, STAT_UNDER, 1'b1));
        end else begin
          stack_count--;
          owed_results.push_back(make_result(stack_words[stack_count], STAT_OK, 1'b1));
        end
      end
      FUNC_PEEK: begin
        if (stack_count == 0) begin
          owed_results.push_back(make_result('0, STAT_UNDER, 1'b1));
        end else begin
          owed_results.push_back(make_result(stack_words[stack_count-1], STAT_OK, 1'b1));
        end
      end
      default: begin
        // Dump walks from the top word down; only the bottom word closes the item.
        if (stack_count == 0) begin
          owed_results.push_back(make_result('0, STAT_UNDER, 1'b1));
        end else begin
          for (int i = stack_count; i > 0; i--) begin
            owed_results.push_back(make_result(stack_words[i-1], STAT_OK, i == 1));
          end
        end
      end
    endcase
  endfunction

  // Offers one item, with a random gap first, and returns at the falling edge after it
  // was taken. tvalid stays high so that the next call can follow without a bubble.
  task automatic send_op(func_e op, logic [DATA_W-1:0] value);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_stack_op(op, value);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] corner [4];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // push_pct steers the mix between pushes and pops so the stack sweeps its range.
  task automatic send_random_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) send_op(FUNC_DUMP, pick_value());
    else if (r < 16) send_op(FUNC_PEEK, pick_value());
    else if ($urandom_range(0, 99) < push_pct) send_op(FUNC_PUSH, pick_value());
    else send_op(FUNC_POP, pick_value());
  endtask

  // Receiver: random stalls, or a hold-off of a requested number of cycles.
  initial begin : sink_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (idle_en) begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void note_field_mismatch(string field, logic [DATA_W-1:0] want,
                                              logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("%0t: result with no item outstanding, tdata %h", $time, m_axis_tdata);
        end
      end else begin
        stack_result_t want;
        want = owed_results.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.data)
          note_field_mismatch("data", want.data, m_axis_tdata[DATA_W-1:0]);
        if (m_axis_tdata[DATA_W] !== want.empty)
          note_field_mismatch("is_empty", want.empty, m_axis_tdata[DATA_W]);
        if (m_axis_tdata[DATA_W+1] !== want.full)
          note_field_mismatch("is_full", want.full, m_axis_tdata[DATA_W+1]);
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0)
          note_field_mismatch("tdata padding", '0, m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]);
        if (m_axis_tuser !== want.status)
          note_field_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tlast !== want.tlast)
          note_field_mismatch("last", want.tlast, m_axis_tlast);
      end
    end
  end

  // Pop, peek and dump on an empty stack must each be refused with an underflow.
  task automatic test_empty_errors();
    send_op(FUNC_POP, pick_value());
    send_op(FUNC_PEEK, pick_value());
    send_op(FUNC_DUMP, pick_value());
  endtask

  task automatic test_extreme_values();
    send_op(FUNC_PUSH, 32'h8000_0000);
    send_op(FUNC_PUSH, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH, 32'h0000_0000);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH, 32'h5555_5555);
    send_op(FUNC_PUSH, 32'hAAAA_AAAA);
    send_op(FUNC_PEEK, 32'hFFFF_FFFF);
    send_op(FUNC_DUMP, 32'h0000_0000);
    repeat (6) send_op(FUNC_POP, pick_value());
    send_op(FUNC_POP, 32'hFFFF_FFFF);
    send_op(FUNC_PEEK, 32'h0000_0000);
  endtask

  // Fill to the brim, push into a full stack, dump all words, then empty it again.
  task automatic test_full_stack();
    while (stack_count < DEPTH) send_op(FUNC_PUSH, pick_value());
    send_op(FUNC_PUSH, pick_value());
    send_op(FUNC_PUSH, pick_value());
    send_op(FUNC_PEEK, pick_value());
    send_op(FUNC_DUMP, pick_value());
    send_op(FUNC_POP, pick_value());
    send_op(FUNC_PUSH, pick_value());
    send_op(FUNC_DUMP, pick_value());
    while (stack_count > 0) begin
      if ($urandom_range(0, 3) == 0) send_op(FUNC_PEEK, pick_value());
      else send_op(FUNC_POP, pick_value());
    end
    send_op(FUNC_DUMP, pick_value());
  endtask

  // The receiver stops for a long stretch while items keep coming, so the block backs up
  // and refuses input; afterwards the sender waits until every result is out.
  task automatic test_sink_hold_off();
    sink_hold_req = HOLD_CYCLES;
    repeat (HOLD_ITEMS / 2) send_op(FUNC_PUSH, pick_value());
    send_op(FUNC_DUMP, pick_value());
    repeat (HOLD_ITEMS / 2 - 1) send_random_op(50);
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (BURST_ITEMS) send_random_op(55);
    wait_results_drained();
    idle_en = 1'b1;
  endtask

  // Phases alternate between filling and draining so that both ends are hit often.
  task automatic test_random_ops();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    sent = 0;
    push_pct = 75;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 70);
      repeat (phase_len) begin
        send_random_op(push_pct);
        sent++;
      end
      push_pct = (push_pct > 50) ? 25 : 75;
    end
  endtask

  initial begin : run_tests
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_errors();
    test_extreme_values();
    test_full_stack();
    test_sink_hold_off();
    test_back_to_back();
    test_random_ops();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("lifo_stack_engine verification clean");
    end else begin
      $display("lifo_stack_engine verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("lifo_stack_engine verification failed");
    $finish;
  end

endmodule
